/* hw/rtl/segment_tree_range_sum_assert.svh */
// Assertion macros for the segment tree range-sum block.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef SEGMENT_TREE_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define STRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define STRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/strs_pkg.sv */
// Package for the segment tree range-sum block: field widths, beat layout,
// command codes and the controller state type. No dependencies.
`default_nettype none

package strs_pkg;

    localparam int LEAVES_DEF = 1024;

    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;
    localparam int DATA_W = 64;

    // Input tdata layout, lowest bit first
    localparam int LEAF_LSB = 0;
    localparam int VAL_LSB  = LEAF_LSB + IDX_W;
    localparam int LO_LSB   = VAL_LSB + VAL_W;
    localparam int HI_LSB   = LO_LSB + IDX_W;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_QRY_WALK,
        ST_QRY_DONE
    } strs_state_t;

endpackage

`default_nettype wire

/* hw/rtl/segment_tree_range_sum.sv */
// Segment tree range-sum engine: point updates and inclusive range-sum queries
// over one synchronous tree memory. Depends on strs_pkg and the assertion header.
//
//   channel   dir   handshake                        payload
//   s_axis    in    s_axis_tvalid / s_axis_tready    tuser = cmd, tdata = update/query fields
//   m_axis    out   m_axis_tvalid / m_axis_tready    tdata = range_sum
//
// Update: one tree level per cycle from the leaf up to the root; the sibling read of each
//   level sets the pace.
// Query: both bounds are read per level through two read ports, then the partial sums
//   are added into the result.
// After reset a clearing pass zeroes all 2*LEAVES entries, one per cycle (2048 at 1024).
// One item at a time; a new item is taken while a result waits, a later query then holds.
`default_nettype none

module segment_tree_range_sum #(
    parameter int LEAVES = strs_pkg::LEAVES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] leaf_index, [41:10] value, [51:42] range_low, [61:52] range_high, [63:62] zero
    input  wire logic [strs_pkg::DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [63:0] range_sum
    output logic [strs_pkg::SUM_W-1:0]       m_axis_tdata
);

    import strs_pkg::*;

`include "segment_tree_range_sum_assert.svh"

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int CW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

    strs_state_t state_reg, state_next;

    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    node_reg, node_next;
    logic [SUM_W-1:0] cur_reg, cur_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [AW-1:0]    b_reg, b_next;
    logic [SUM_W-1:0] acc_lo_reg, acc_lo_next;
    logic [SUM_W-1:0] acc_hi_reg, acc_hi_next;
    logic             acc0_vld_reg, acc0_vld_next;
    logic             acc1_vld_reg, acc1_vld_next;
    logic [SUM_W-1:0] out_data_reg, out_data_next;
    logic             out_vld_reg, out_vld_next;
    logic [SUM_W-1:0] rdata0_reg, rdata1_reg;

    // Tree memory port controls
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [SUM_W-1:0] wr_data;
    logic             rd0_en, rd1_en;
    logic [AW-1:0]    rd0_addr, rd1_addr;

    logic [SUM_W-1:0] tree_mem [NODES];

    // Input beat decode
    logic             s_fire;
    logic             cmd;
    logic [IDX_W-1:0] leaf_index, range_low, range_high;
    logic [VAL_W-1:0] value;
    logic [CW-1:0]    leaves_w, idx_w, lo_w, hi_w, hi_sat;
    logic             idx_ok, q_empty;
    logic [AW-1:0]    leaf_node, a_start, b_start;

    // Walk and climb helpers
    logic             walk_go;
    logic [AW:0]      a_inc;
    logic [AW-1:0]    b_dec;
    logic [AW-1:0]    parent;
    logic [SUM_W-1:0] up_sum;
    logic             out_free;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign cmd        = s_axis_tuser;
    assign leaf_index = s_axis_tdata[LEAF_LSB +: IDX_W];
    assign value      = s_axis_tdata[VAL_LSB +: VAL_W];
    assign range_low  = s_axis_tdata[LO_LSB +: IDX_W];
    assign range_high = s_axis_tdata[HI_LSB +: IDX_W];

    assign leaves_w  = CW'(LEAVES);
    assign idx_w     = CW'(leaf_index);
    assign lo_w      = CW'(range_low);
    assign hi_w      = CW'(range_high);
    assign hi_sat    = (hi_w >= leaves_w) ? (leaves_w - CW'(1)) : hi_w;
    assign idx_ok    = idx_w < leaves_w;
    assign q_empty   = (lo_w >= leaves_w) || (lo_w > hi_sat);
    assign leaf_node = AW'(idx_w + leaves_w);
    assign a_start   = AW'(lo_w + leaves_w);
    assign b_start   = AW'(hi_sat + leaves_w);

    assign walk_go  = a_reg <= b_reg;
    assign a_inc    = {1'b0, a_reg} + (AW+1)'(a_reg[0]);
    assign b_dec    = b_reg - AW'(!b_reg[0]);
    assign parent   = node_reg >> 1;
    assign up_sum   = cur_reg + rdata0_reg;
    assign out_free = !out_vld_reg || m_axis_tready;

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(NODES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (cmd == CMD_UPDATE)
                        state_next = idx_ok ? ST_UPD_LEAF : ST_IDLE;
                    else
                        state_next = q_empty ? ST_QRY_DONE : ST_QRY_WALK;
                end
            end
            ST_UPD_LEAF: state_next = ST_UPD_UP;
            ST_UPD_UP:
            begin
                if (parent == AW'(1))
                    state_next = ST_IDLE;
            end
            ST_QRY_WALK:
            begin
                // last reads land this cycle and are summed at its end
                if (!walk_go)
                    state_next = ST_QRY_DONE;
            end
            ST_QRY_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath and memory port controls
    always_comb
    begin
        clr_next      = clr_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_lo_next   = acc0_vld_reg ? (acc_lo_reg + rdata0_reg) : acc_lo_reg;
        acc_hi_next   = acc1_vld_reg ? (acc_hi_reg + rdata1_reg) : acc_hi_reg;
        acc0_vld_next = 1'b0;
        acc1_vld_next = 1'b0;
        out_data_next = out_data_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        wr_en         = 1'b0;
        wr_addr       = node_reg;
        wr_data       = cur_reg;
        rd0_en        = 1'b0;
        rd0_addr      = node_reg ^ AW'(1);
        rd1_en        = 1'b0;
        rd1_addr      = b_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    node_next   = leaf_node;
                    cur_next    = {{(SUM_W - VAL_W){value[VAL_W-1]}}, value};
                    a_next      = a_start;
                    b_next      = b_start;
                    acc_lo_next = '0;
                    acc_hi_next = '0;
                end
            end
            ST_UPD_LEAF:
            begin
                // write the leaf and fetch its sibling in the same cycle
                wr_en  = 1'b1;
                rd0_en = 1'b1;
            end
            ST_UPD_UP:
            begin
                // parent never equals the sibling read for the next level
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = up_sum;
                cur_next  = up_sum;
                node_next = parent;
                rd0_en    = parent != AW'(1);
                rd0_addr  = parent ^ AW'(1);
            end
            ST_QRY_WALK:
            begin
                if (walk_go)
                begin
                    rd0_en        = a_reg[0];
                    rd0_addr      = a_reg;
                    rd1_en        = !b_reg[0];
                    acc0_vld_next = a_reg[0];
                    acc1_vld_next = !b_reg[0];
                    a_next        = AW'(a_inc >> 1);
                    b_next        = b_dec >> 1;
                end
            end
            ST_QRY_DONE:
            begin
                if (out_free)
                begin
                    out_data_next = acc_lo_reg + acc_hi_reg;
                    out_vld_next  = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            acc0_vld_reg <= 1'b0;
            acc1_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            acc0_vld_reg <= acc0_vld_next;
            acc1_vld_reg <= acc1_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        cur_reg      <= cur_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_lo_reg   <= acc_lo_next;
        acc_hi_reg   <= acc_hi_next;
        out_data_reg <= out_data_next;
    end

    // Tree memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tree_mem[wr_addr] <= wr_data;
        if (rd0_en)
            rdata0_reg <= tree_mem[rd0_addr];
        if (rd1_en)
            rdata1_reg <= tree_mem[rd1_addr];
    end

    `STRS_ASSERT_NOW(a_no_wr_in_query,
        (state_reg == ST_QRY_WALK || state_reg == ST_QRY_DONE), !wr_en,
        "tree written during a query")
    `STRS_ASSERT_NOW(a_rd_wr_apart, (wr_en && rd0_en), (wr_addr != rd0_addr),
        "read and write hit the same tree entry")
    `STRS_ASSERT_NOW(a_climb_above_root, (state_reg == ST_UPD_UP), (node_reg > AW'(1)),
        "update climbed past the root")
    `STRS_ASSERT_NEXT(a_result_held,
        (state_reg == ST_QRY_DONE && out_vld_reg && !m_axis_tready),
        (state_reg == ST_QRY_DONE), "query result dropped while output slot busy")

endmodule

`default_nettype wire
